@@ hw/rtl/pths_pkg.sv @@
// Shared types and constants of the timer heap scheduler.
`timescale 1ns / 1ps
package pths_pkg;

    localparam int CAPACITY_DEF = 32;

    localparam logic [1:0] MODE_CREATE = 2'd0;
    localparam logic [1:0] MODE_KILL   = 2'd1;
    localparam logic [1:0] MODE_TICK   = 2'd2;

    localparam logic [2:0] KIND_CREATED = 3'd0;
    localparam logic [2:0] KIND_REFUSED = 3'd1;
    localparam logic [2:0] KIND_FIRED   = 3'd2;
    localparam logic [2:0] KIND_TICK    = 3'd3;
    localparam logic [2:0] KIND_KILL    = 3'd4;

    localparam int FLAG_KILLED  = 0;
    localparam int FLAG_PENDING = 1;

    typedef struct packed {
        logic [32:0] expiry;
        logic [31:0] ident;
        logic [30:0] interval;
        logic [15:0] remaining;
        logic [1:0]  flags;
    } heap_entry_t;

    typedef struct packed {
        logic [31:0] ident;
        logic [30:0] interval;
        logic [15:0] remaining;
        logic [1:0]  flags;
    } due_entry_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INS_CHK,
        ST_INS_CMP,
        ST_KILL_RD,
        ST_KILL_CHK,
        ST_POP_RD,
        ST_POP_CHK,
        ST_LAST_RD,
        ST_LAST_LD,
        ST_SD_L,
        ST_SD_LD,
        ST_SD_RD,
        ST_SD_CMP,
        ST_DUE_RD,
        ST_DUE_PROC
    } state_t;

endpackage

@@ hw/rtl/pths_if.sv @@
// Request and response channel interfaces of the timer heap scheduler.
`timescale 1ns / 1ps
interface pths_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [31:0] now;
    logic [30:0] delay;
    logic [30:0] period;
    logic [15:0] repeat_req;
    logic [31:0] kill_id;
    modport source (output valid, mode, now, delay, period, repeat_req, kill_id,
                    input ready);
    modport sink (input valid, mode, now, delay, period, repeat_req, kill_id,
                  output ready);
endinterface

interface pths_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [31:0] tid;
    logic        hit;
    logic        last;
    modport source (output valid, kind, tid, hit, last, input ready);
    modport sink (input valid, kind, tid, hit, last, output ready);
endinterface

@@ hw/rtl/pths_ram.sv @@
// Single-port-write, single-port-read synchronous RAM with registered read data.
`timescale 1ns / 1ps
module pths_ram
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

@@ hw/rtl/periodic_timer_heap_scheduler.sv @@
// Top level of the timer heap scheduler: command sequencer over the heap and due RAMs.
`timescale 1ns / 1ps
// Usage:
//   req channel carries one command per transfer: create (mode 0), kill (mode 1),
//   tick (mode 2); mode 3 is taken and ignored. rsp channel returns results:
//   created/refused, kill done with hit, fired ids, then tick done; last marks
//   the final result of a command.
//   Timers live in a binary min-heap in one RAM with registered read data; the
//   due list of a tick lives in a second RAM.
//   Create answers at once and then sifts up, one heap level per step. Kill
//   scans the heap entry by entry. Tick pops each due timer and sifts the last
//   entry down from the root, then handles each due timer and sifts back in
//   each one that stays live; the single heap RAM read port sets the pace of
//   every phase.
//   One command is worked at a time; req.ready is high only when idle and the
//   result register can take a new result.
//   Reset empties the heap and clears the id counter; RAM contents need no clear.
//   When the receiver stalls, the result register holds and the sequencer
//   waits before emitting the next result.
module periodic_timer_heap_scheduler
    import pths_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)
(
    input  logic          clk,
    input  logic          rst_n,
    pths_req_if.sink      req,
    pths_rsp_if.source    rsp
);
    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int HW = $bits(heap_entry_t);
    localparam int DW = $bits(due_entry_t);

    state_t       state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] nd_reg, nd_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [CW-1:0] bidx_reg, bidx_next;
    heap_entry_t  x_reg, x_next;
    heap_entry_t  best_reg, best_next;
    logic [31:0]  now_reg, now_next;
    logic [31:0]  kid_reg, kid_next;
    logic [31:0]  ctr_reg, ctr_next;
    logic         tick_reg, tick_next;

    logic         ovalid_reg;
    logic [2:0]   okind_reg;
    logic [31:0]  oid_reg;
    logic         ohit_reg, olast_reg;
    logic         out_load;
    logic [2:0]   out_kind;
    logic [31:0]  out_id;
    logic         out_hit, out_last;
    logic         slot_free;

    logic          h_we, h_re, d_we, d_re;
    logic [AW-1:0] h_waddr, h_raddr, d_waddr, d_raddr;
    heap_entry_t   h_wdata, h_rdata;
    due_entry_t    d_wdata, d_rdata;
    logic [HW-1:0] h_rbits;
    logic [DW-1:0] d_rbits;

    logic [CW-1:0] parent;
    logic [CW:0]   lchild, rchild;
    logic [31:0]   ctr_inc;
    heap_entry_t   rd_killed;

    pths_ram #(.WIDTH(HW), .DEPTH(CAPACITY)) u_heap_ram (
        .clk   (clk),
        .we    (h_we),
        .waddr (h_waddr),
        .wdata (h_wdata),
        .re    (h_re),
        .raddr (h_raddr),
        .rdata (h_rbits)
    );

    pths_ram #(.WIDTH(DW), .DEPTH(CAPACITY)) u_due_ram (
        .clk   (clk),
        .we    (d_we),
        .waddr (d_waddr),
        .wdata (d_wdata),
        .re    (d_re),
        .raddr (d_raddr),
        .rdata (d_rbits)
    );

    assign h_rdata = h_rbits;
    assign d_rdata = d_rbits;

    assign slot_free = !ovalid_reg || rsp.ready;
    assign parent    = (idx_reg - CW'(1)) >> 1;
    assign lchild    = {idx_reg, 1'b1};
    assign rchild    = {idx_reg, 1'b0} + (CW+1)'(2);
    assign ctr_inc   = (ctr_reg + 32'd1 == 32'd0) ? 32'd1 : ctr_reg + 32'd1;

    always_comb
    begin
        rd_killed = h_rdata;
        rd_killed.flags[FLAG_KILLED] = 1'b1;
    end

    assign req.ready = (state_reg == ST_IDLE) && slot_free;

    // Sequencer: next state, RAM control and result load.
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        nd_next    = nd_reg;
        idx_next   = idx_reg;
        bidx_next  = bidx_reg;
        x_next     = x_reg;
        best_next  = best_reg;
        now_next   = now_reg;
        kid_next   = kid_reg;
        ctr_next   = ctr_reg;
        tick_next  = tick_reg;
        h_we = 1'b0; h_waddr = '0; h_wdata = x_reg;
        h_re = 1'b0; h_raddr = '0;
        d_we = 1'b0; d_waddr = '0;
        d_wdata = '{h_rdata.ident, h_rdata.interval, h_rdata.remaining, h_rdata.flags};
        d_re = 1'b0; d_raddr = '0;
        out_load = 1'b0; out_kind = KIND_TICK; out_id = '0; out_hit = 1'b0; out_last = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (req.valid && slot_free)
                begin
                    now_next  = req.now;
                    kid_next  = req.kill_id;
                    tick_next = 1'b0;
                    case (req.mode)
                        MODE_CREATE:
                        begin
                            out_load = 1'b1;
                            out_last = 1'b1;
                            if (count_reg == CW'(CAPACITY))
                            begin
                                out_kind = KIND_REFUSED;
                            end
                            else
                            begin
                                out_kind = KIND_CREATED;
                                out_id   = ctr_inc;
                                ctr_next = ctr_inc;
                                x_next.ident     = ctr_inc;
                                x_next.interval  = req.period;
                                x_next.remaining = req.repeat_req;
                                if (req.delay != '0)
                                begin
                                    x_next.expiry = {1'b0, req.now} + 33'(req.delay);
                                    x_next.flags  = 2'b10;
                                end
                                else
                                begin
                                    x_next.expiry = {1'b0, req.now} + 33'(req.period);
                                    x_next.flags  = 2'b00;
                                end
                                idx_next   = count_reg;
                                count_next = count_reg + CW'(1);
                                state_next = ST_INS_CHK;
                            end
                        end
                        MODE_KILL:
                        begin
                            if (count_reg == '0)
                            begin
                                out_load = 1'b1;
                                out_kind = KIND_KILL;
                                out_last = 1'b1;
                            end
                            else
                            begin
                                idx_next   = '0;
                                state_next = ST_KILL_RD;
                            end
                        end
                        MODE_TICK:
                        begin
                            tick_next  = 1'b1;
                            nd_next    = '0;
                            state_next = ST_POP_RD;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            // Sift up: move parents down until the hole fits x.
            ST_INS_CHK:
            begin
                if (idx_reg == '0)
                begin
                    h_we = 1'b1; h_waddr = AW'(idx_reg); h_wdata = x_reg;
                    state_next = tick_reg ? ST_DUE_RD : ST_IDLE;
                end
                else
                begin
                    h_re = 1'b1; h_raddr = AW'(parent);
                    state_next = ST_INS_CMP;
                end
            end
            ST_INS_CMP:
            begin
                h_we = 1'b1; h_waddr = AW'(idx_reg);
                if (x_reg.expiry < h_rdata.expiry)
                begin
                    h_wdata    = h_rdata;
                    idx_next   = parent;
                    state_next = ST_INS_CHK;
                end
                else
                begin
                    h_wdata    = x_reg;
                    state_next = tick_reg ? ST_DUE_RD : ST_IDLE;
                end
            end
            ST_KILL_RD:
            begin
                h_re = 1'b1; h_raddr = AW'(idx_reg);
                state_next = ST_KILL_CHK;
            end
            ST_KILL_CHK:
            begin
                if (h_rdata.ident == kid_reg && !h_rdata.flags[FLAG_KILLED])
                begin
                    if (slot_free)
                    begin
                        h_we = 1'b1; h_waddr = AW'(idx_reg); h_wdata = rd_killed;
                        out_load = 1'b1; out_kind = KIND_KILL; out_hit = 1'b1;
                        out_last = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
                else if (idx_reg + CW'(1) == count_reg)
                begin
                    if (slot_free)
                    begin
                        out_load = 1'b1; out_kind = KIND_KILL; out_last = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    idx_next   = idx_reg + CW'(1);
                    state_next = ST_KILL_RD;
                end
            end
            // Pop phase: move due roots into the due list.
            ST_POP_RD:
            begin
                if (count_reg == '0)
                begin
                    state_next = ST_DUE_RD;
                end
                else
                begin
                    h_re = 1'b1; h_raddr = '0;
                    state_next = ST_POP_CHK;
                end
            end
            ST_POP_CHK:
            begin
                if (h_rdata.expiry <= {1'b0, now_reg})
                begin
                    d_we = 1'b1; d_waddr = AW'(nd_reg);
                    nd_next    = nd_reg + CW'(1);
                    count_next = count_reg - CW'(1);
                    state_next = (count_reg == CW'(1)) ? ST_DUE_RD : ST_LAST_RD;
                end
                else
                begin
                    state_next = ST_DUE_RD;
                end
            end
            ST_LAST_RD:
            begin
                h_re = 1'b1; h_raddr = AW'(count_reg);
                state_next = ST_LAST_LD;
            end
            ST_LAST_LD:
            begin
                x_next     = h_rdata;
                idx_next   = '0;
                state_next = ST_SD_L;
            end
            // Sift down with a hole at idx holding x.
            ST_SD_L:
            begin
                if (lchild >= {1'b0, count_reg})
                begin
                    h_we = 1'b1; h_waddr = AW'(idx_reg); h_wdata = x_reg;
                    state_next = ST_POP_RD;
                end
                else
                begin
                    h_re = 1'b1; h_raddr = AW'(lchild);
                    state_next = ST_SD_LD;
                end
            end
            ST_SD_LD:
            begin
                best_next = h_rdata;
                bidx_next = CW'(lchild);
                if (rchild < {1'b0, count_reg})
                begin
                    h_re = 1'b1; h_raddr = AW'(rchild);
                    state_next = ST_SD_RD;
                end
                else
                begin
                    state_next = ST_SD_CMP;
                end
            end
            ST_SD_RD:
            begin
                if (h_rdata.expiry < best_reg.expiry)
                begin
                    best_next = h_rdata;
                    bidx_next = CW'(rchild);
                end
                state_next = ST_SD_CMP;
            end
            ST_SD_CMP:
            begin
                h_we = 1'b1; h_waddr = AW'(idx_reg);
                if (best_reg.expiry < x_reg.expiry)
                begin
                    h_wdata    = best_reg;
                    idx_next   = bidx_reg;
                    state_next = ST_SD_L;
                end
                else
                begin
                    h_wdata    = x_reg;
                    state_next = ST_POP_RD;
                end
            end
            // Handle phase: walk the due list from its last entry.
            ST_DUE_RD:
            begin
                if (nd_reg == '0)
                begin
                    if (slot_free)
                    begin
                        out_load = 1'b1; out_kind = KIND_TICK; out_last = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    d_re = 1'b1; d_raddr = AW'(nd_reg - CW'(1));
                    nd_next    = nd_reg - CW'(1);
                    state_next = ST_DUE_PROC;
                end
            end
            ST_DUE_PROC:
            begin
                x_next.expiry    = {1'b0, now_reg} + 33'(d_rdata.interval);
                x_next.ident     = d_rdata.ident;
                x_next.interval  = d_rdata.interval;
                x_next.remaining = d_rdata.remaining;
                x_next.flags     = 2'b00;
                if (d_rdata.flags[FLAG_KILLED])
                begin
                    state_next = ST_DUE_RD;
                end
                else if (d_rdata.flags[FLAG_PENDING])
                begin
                    idx_next   = count_reg;
                    count_next = count_reg + CW'(1);
                    state_next = ST_INS_CHK;
                end
                else if (slot_free)
                begin
                    out_load = 1'b1; out_kind = KIND_FIRED; out_id = d_rdata.ident;
                    if (d_rdata.remaining == 16'd1)
                    begin
                        state_next = ST_DUE_RD;
                    end
                    else
                    begin
                        if (d_rdata.remaining != '0)
                        begin
                            x_next.remaining = d_rdata.remaining - 16'd1;
                        end
                        idx_next   = count_reg;
                        count_next = count_reg + CW'(1);
                        state_next = ST_INS_CHK;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            count_reg  <= '0;
            nd_reg     <= '0;
            ctr_reg    <= '0;
            tick_reg   <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            nd_reg    <= nd_next;
            ctr_reg   <= ctr_next;
            tick_reg  <= tick_next;
            if (out_load)
            begin
                ovalid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                ovalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg  <= idx_next;
        bidx_reg <= bidx_next;
        x_reg    <= x_next;
        best_reg <= best_next;
        now_reg  <= now_next;
        kid_reg  <= kid_next;
        if (out_load)
        begin
            okind_reg <= out_kind;
            oid_reg   <= out_id;
            ohit_reg  <= out_hit;
            olast_reg <= out_last;
        end
    end

    assign rsp.valid = ovalid_reg;
    assign rsp.kind  = okind_reg;
    assign rsp.tid   = oid_reg;
    assign rsp.hit   = ohit_reg;
    assign rsp.last  = olast_reg;

    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("heap count above capacity");

    a_due_cap: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, nd_reg} + {1'b0, count_reg}) <= (CW+1)'(CAPACITY))
        else $error("due list and heap exceed capacity");

    a_no_load_stall: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> slot_free)
        else $error("result loaded over a stalled result");

    a_heap_waddr: assert property (@(posedge clk) disable iff (!rst_n)
        h_we |-> ({1'b0, h_waddr} < (AW+1)'(CAPACITY)))
        else $error("heap write beyond capacity");
endmodule
